FILE: design/srm_pkg.sv
// Package for the small register machine execution core.
// Holds sizes, opcode, operand kind and status codes, controller states, shared structs and the flag function.
package srm_pkg;
    localparam int NumRegs  = 7;
    localparam int MemWords = 64;
    localparam int RegIdxW  = 3;
    localparam int MemAdrW  = $clog2(MemWords);
    localparam int DataW    = 32;
    localparam int PcW      = 16;

    typedef enum logic [3:0] {
        OP_MOV = 4'd0, OP_ADD = 4'd1, OP_SUB = 4'd2, OP_MUL = 4'd3,
        OP_DIV = 4'd4, OP_INC = 4'd5, OP_DEC = 4'd6, OP_IN = 4'd7,
        OP_OUT = 4'd8, OP_LOAD = 4'd9, OP_STORE = 4'd10, OP_SHL = 4'd11,
        OP_SHR = 4'd12, OP_ROL = 4'd13, OP_ROR = 4'd14, OP_BAD = 4'd15
    } t_op;

    typedef enum logic [1:0] {
        KIND_REG = 2'd0, KIND_IMM = 2'd1, KIND_MEM = 2'd2, KIND_IND = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_INVALID = 2'd1, ST_DIV_ZERO = 2'd2, ST_RSVD = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE, S_FETCH1, S_FETCH2, S_FETCH3, S_ITER, S_DONE, S_OUT
    } t_state;

    // Request to and answer from the shared multiply/divide unit.
    typedef struct packed {
        logic start;
        logic is_div;
    } t_md_req;

    typedef struct packed {
        logic done;
    } t_md_rsp;

    // Input beat payload.
    typedef struct packed {
        logic [3:0]  op;
        logic [1:0]  first_kind;
        logic [2:0]  first_reg;
        logic [30:0] first_num;
        logic [1:0]  second_kind;
        logic [2:0]  second_reg;
        logic [30:0] second_num;
        logic [31:0] in_value;
    } t_in_item;

    // Output beat payload.
    typedef struct packed {
        logic [15:0] pc;
        logic [1:0]  status;
        logic [31:0] out_value;
        logic        flag_over;
        logic        flag_under;
        logic        flag_carry;
        logic        flag_zero;
    } t_out_item;

    // Flags of a signed 32-bit result: over, under, carry, zero.
    function automatic logic [3:0] calc_flags(input logic [31:0] r);
        logic neg;
        neg = r[31];
        calc_flags[3] = !neg && (r != 32'd0) && (r <= 32'd254);
        calc_flags[2] = neg;
        calc_flags[1] = !neg && (r > 32'd255);
        calc_flags[0] = (r == 32'd0);
    endfunction
endpackage

FILE: design/srm_if.sv
// Valid/ready channel interface for the register machine beats.
// Depends on srm_pkg for the input and output payload structs.
interface srm_in_if;
    logic        valid;
    logic        ready;
    srm_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface srm_out_if;
    logic        valid;
    logic        ready;
    srm_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/srm_muldiv.sv
// Shared iterative multiply/divide unit: one bit per cycle.
// Depends on srm_pkg. Divide is signed, truncating; multiply keeps low 32 bits.
module srm_muldiv (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  srm_pkg::t_md_req   i_req,
    input  logic [31:0]        i_a,
    input  logic [31:0]        i_b,
    output srm_pkg::t_md_rsp   o_rsp,
    output logic [31:0]        o_result
);
    import srm_pkg::*;

    logic        r_busy, n_busy;
    logic        r_div;
    logic [4:0]  r_cnt;
    logic        r_neg;
    logic [31:0] r_acc;   // product or remainder
    logic [31:0] r_q;     // multiplier or dividend/quotient
    logic [31:0] r_b;     // multiplicand or divisor magnitude
    logic        r_done;
    logic [32:0] rem_try;
    logic [31:0] rem_sh;

    // Next remainder for one restoring step.
    always_comb begin
        rem_sh  = {r_acc[30:0], r_q[31]};
        rem_try = {1'b0, rem_sh} - {1'b0, r_b};
    end

    always_comb begin
        n_busy = r_busy;
        if (i_req.start) begin
            n_busy = 1'b1;
        end else if (r_busy && r_cnt == 5'd31) begin
            n_busy = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= r_busy && r_cnt == 5'd31;
            if (i_req.start) begin
                r_cnt <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
            end
        end
    end

    // Datapath: load operands, then one step per cycle.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_div <= i_req.is_div;
            r_acc <= '0;
            if (i_req.is_div) begin
                r_neg <= i_a[31] ^ i_b[31];
                r_q   <= i_a[31] ? 32'd0 - i_a : i_a;
                r_b   <= i_b[31] ? 32'd0 - i_b : i_b;
            end else begin
                r_neg <= 1'b0;
                r_q   <= i_b;
                r_b   <= i_a;
            end
        end else if (r_busy) begin
            if (r_div) begin
                if (!rem_try[32]) begin
                    r_acc <= rem_try[31:0];
                    r_q   <= {r_q[30:0], 1'b1};
                end else begin
                    r_acc <= rem_sh;
                    r_q   <= {r_q[30:0], 1'b0};
                end
            end else begin
                r_acc <= (r_q[0] ? r_acc + r_b : r_acc);
                r_b   <= {r_b[30:0], 1'b0};
                r_q   <= {1'b0, r_q[31:1]};
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_result   = r_div ? (r_neg ? 32'd0 - r_q : r_q) : r_acc;

    // Done pulses only right after the last step.
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("muldiv done without busy");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_cnt != 5'd31 |=> r_busy) else $error("muldiv dropped early");
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("muldiv done held");
endmodule

FILE: design/small_register_machine_exec_core.sv
// Top level of the small register machine execution core.
// Depends on srm_pkg, srm_if and srm_muldiv.
//
//  channel  dir  payload
//  i_in     in   op, operand kinds/regs/nums, in_value
//  o_out    out  pc, status, out_value, four flags
//
// An instruction runs from one accepted input beat to the next through the
// fetch states FETCH1, FETCH2 and FETCH3 (two reads through the single
// registered read port of the data memory), commit in DONE, and the output
// beat in OUT. MUL and DIV also pass through ITER in the bit-serial
// multiply/divide unit. Input is not ready while an instruction runs or its
// result waits. Reset clears registers, flags and pc at once; the data memory
// has one valid bit per word.
module small_register_machine_exec_core (
    input  logic i_clk,
    input  logic i_rst_n,
    srm_in_if.sink    i_in,
    srm_out_if.source o_out
);
    import srm_pkg::*;

    t_state r_state, n_state;
    t_in_item r_item;
    logic [31:0] r_regs [NumRegs];
    logic [31:0] r_mem [MemWords];
    logic [MemWords-1:0] r_mvld;
    logic [3:0]  r_flags;
    logic [15:0] r_pc;
    logic [31:0] r_v1, r_v2;
    logic        r_bad;
    t_out_item   r_out;
    logic        r_ovld;

    t_md_req     md_req;
    t_md_rsp     md_rsp;
    logic [31:0] md_res;

    // Decoded view of the held item.
    t_op   op;
    t_kind k1, k2, k2a;
    logic  r1_ok, r2_ok;
    logic [31:0] reg1, reg2;
    logic  a1_ok, a2_ok;
    logic [MemAdrW-1:0] a1, a2, rd_adr;
    logic [31:0] rd_data;
    logic  rd_valid;
    logic [31:0] imm1, imm2;
    logic  fetch_second;

    assign op    = t_op'(r_item.op);
    assign k1    = t_kind'(r_item.first_kind);
    assign k2    = t_kind'(r_item.second_kind);
    assign k2a   = (k2 == KIND_IMM) ? KIND_MEM : k2;
    assign r1_ok = r_item.first_reg < 3'(NumRegs);
    assign r2_ok = r_item.second_reg < 3'(NumRegs);
    assign reg1  = r1_ok ? r_regs[r_item.first_reg] : 32'd0;
    assign reg2  = r2_ok ? r_regs[r_item.second_reg] : 32'd0;
    assign imm1  = {1'b0, r_item.first_num};
    assign imm2  = {1'b0, r_item.second_num};

    // Address of each operand for memory kinds.
    always_comb begin
        a1_ok = 1'b0;
        a1    = '0;
        if (k1 == KIND_MEM) begin
            a1_ok = imm1 < 32'(MemWords);
            a1    = imm1[MemAdrW-1:0];
        end else if (k1 == KIND_IND) begin
            a1_ok = r1_ok && reg1 < 32'(MemWords);
            a1    = reg1[MemAdrW-1:0];
        end
        a2_ok = 1'b0;
        a2    = '0;
        if (k2a == KIND_MEM) begin
            a2_ok = imm2 < 32'(MemWords);
            a2    = imm2[MemAdrW-1:0];
        end else if (k2a == KIND_IND) begin
            a2_ok = r2_ok && reg2 < 32'(MemWords);
            a2    = reg2[MemAdrW-1:0];
        end
    end

    // First address read in FETCH1, second in FETCH2; the registered port gives the data in the next cycle.
    assign fetch_second = (r_state == S_FETCH2);
    assign rd_adr = fetch_second ? a2 : a1;

    // Data memory read port, registered.
    always_ff @(posedge i_clk) begin
        rd_data <= r_mem[rd_adr];
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rd_valid <= 1'b0;
        end else begin
            rd_valid <= r_mvld[rd_adr];
        end
    end
    logic [31:0] mem_q;
    assign mem_q = rd_valid ? rd_data : 32'd0;

    // Operand value, with memory data from the read port.
    logic        ops_ok;
    logic [31:0] v1_now, v2_now;
    assign v1_now = (k1 == KIND_REG) ? reg1 : (k1 == KIND_IMM) ? imm1 : mem_q;
    assign v2_now = (k2 == KIND_REG) ? reg2 : (k2 == KIND_IMM) ? imm2 : mem_q;

    // Operand validity check for two-operand ops.
    logic first_ok, second_ok;
    assign first_ok  = (k1 == KIND_REG) ? r1_ok : (k1 == KIND_IMM) ? 1'b1 : a1_ok;
    assign second_ok = (k2 == KIND_REG) ? r2_ok : (k2 == KIND_IMM) ? 1'b1 : a2_ok;
    assign ops_ok = first_ok && second_ok;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in.valid && i_in.ready) n_state = S_FETCH1;
            S_FETCH1: n_state = S_FETCH2;
            S_FETCH2: n_state = S_FETCH3;
            S_FETCH3: begin
                if (!r_bad && ops_ok && (op == OP_MUL ||
                        (op == OP_DIV && v2_now != 32'd0))) begin
                    n_state = S_ITER;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_ITER:   if (md_rsp.done) n_state = S_DONE;
            S_DONE:   n_state = S_OUT;
            S_OUT:    if (o_out.ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        md_req.start  = 1'b0;
        md_req.is_div = (op == OP_DIV);
        if (r_state == S_FETCH3 && n_state == S_ITER) begin
            md_req.start = 1'b1;
        end
    end
    assign i_in.ready = (r_state == S_IDLE);
    assign o_out.valid = r_ovld;
    assign o_out.data  = r_out;

    // The second operand is taken live: the unit loads it on the start cycle.
    srm_muldiv u_md (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (md_req),
        .i_a      (r_v1),
        .i_b      (v2_now),
        .o_rsp    (md_rsp),
        .o_result (md_res)
    );

    // 8-bit shift and rotate of the first operand.
    function automatic logic [31:0] shift8(input t_op o, input logic [31:0] v,
                                           input logic [31:0] amt);
        logic [7:0]  x;
        logic [2:0]  k;
        logic [15:0] dbl;
        logic        big;
        x   = v[7:0];
        k   = amt[2:0];
        big = amt >= 32'd8;
        dbl = {x, x};
        shift8 = '0;
        unique case (o)
            OP_SHL:  shift8 = big ? 32'd0 : {24'd0, x << k};
            OP_SHR:  shift8 = big ? 32'd0 : {24'd0, x >> k};
            OP_ROL:  shift8 = {24'd0, 8'(dbl >> (4'd8 - {1'b0, k}))};
            default: shift8 = {24'd0, 8'(dbl >> k)};
        endcase
    endfunction

    // Final result computed in S_DONE.
    logic [31:0] res;
    always_comb begin
        priority case (op)
            OP_ADD: res = r_v1 + r_v2;
            OP_SUB: res = r_v1 - r_v2;
            OP_MUL, OP_DIV: res = md_res;
            OP_INC: res = reg1 + 32'd1;
            OP_DEC: res = reg1 - 32'd1;
            OP_IN:  res = r_item.in_value;
            OP_OUT: res = reg1;
            OP_LOAD: res = r_v2;
            default: res = shift8(op, r_v1, r_v2);
        endcase
    end

    // Error check, computed in S_FETCH3 and held.
    logic [1:0] err_now;
    always_comb begin
        err_now = ST_OK;
        priority case (op)
            OP_MOV: begin
                if (k2 != KIND_REG || !r2_ok) err_now = ST_INVALID;
                else if (k1 == KIND_REG && !r1_ok) err_now = ST_INVALID;
                else if ((k1 == KIND_MEM || k1 == KIND_IND) && !a1_ok) err_now = ST_INVALID;
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SHL, OP_SHR, OP_ROL, OP_ROR: begin
                if (!ops_ok) err_now = ST_INVALID;
                else if (op == OP_DIV && v2_now == 32'd0) err_now = ST_DIV_ZERO;
            end
            OP_INC, OP_DEC, OP_IN, OP_OUT: begin
                if (k1 != KIND_REG || !r1_ok) err_now = ST_INVALID;
            end
            OP_LOAD, OP_STORE: begin
                if (k1 != KIND_REG || !r1_ok || !a2_ok) err_now = ST_INVALID;
            end
            default: err_now = ST_INVALID;
        endcase
    end

    logic [1:0] r_err;
    logic       wr_flags, wr_reg, wr_mem;
    logic [RegIdxW-1:0] wr_ridx;
    logic [31:0] wr_rdata, wr_mdata;
    logic [MemAdrW-1:0] wr_madr;

    // Commit decisions in S_DONE.
    always_comb begin
        wr_flags = 1'b0;
        wr_reg   = 1'b0;
        wr_mem   = 1'b0;
        wr_ridx  = r_item.first_reg;
        wr_rdata = res;
        wr_madr  = a2;
        wr_mdata = reg1;
        if (r_state == S_DONE && r_err == ST_OK) begin
            unique case (op)
                OP_MOV: begin
                    if (k1 == KIND_REG || k1 == KIND_IMM) begin
                        wr_reg   = 1'b1;
                        wr_ridx  = r_item.second_reg;
                        wr_rdata = r_v1;
                    end else begin
                        wr_mem   = 1'b1;
                        wr_madr  = a1;
                        wr_mdata = reg2;
                    end
                end
                OP_LOAD:  wr_reg = 1'b1;
                OP_STORE: wr_mem = 1'b1;
                OP_OUT:   wr_flags = 1'b1;
                OP_INC, OP_DEC, OP_IN: begin
                    wr_flags = 1'b1;
                    wr_reg   = 1'b1;
                end
                OP_BAD: wr_flags = 1'b0;
                default: begin
                    wr_flags = 1'b1;
                    wr_reg   = (k1 == KIND_REG);
                end
            endcase
        end
    end

    // Sequencer and architectural state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_flags <= '0;
            r_pc    <= '0;
            r_mvld  <= '0;
            r_ovld  <= 1'b0;
            r_bad   <= 1'b0;
            r_err   <= ST_OK;
            for (int i = 0; i < NumRegs; i++) r_regs[i] <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE) r_bad <= 1'b0;
            if (r_state == S_FETCH3) r_err <= err_now;
            if (wr_flags) r_flags <= calc_flags(res);
            if (wr_reg) r_regs[wr_ridx] <= wr_rdata;
            if (wr_mem) r_mvld[wr_madr] <= 1'b1;
            if (r_state == S_DONE) begin
                r_pc   <= r_pc + 16'd1;
                r_ovld <= 1'b1;
            end else if (r_ovld && o_out.ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // Item, operand, data memory and output payload registers.
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) r_item <= i_in.data;
        if (r_state == S_FETCH2) r_v1 <= v1_now;
        if (r_state == S_FETCH3) r_v2 <= (op == OP_LOAD) ? mem_q : v2_now;
        if (wr_mem) r_mem[wr_madr] <= wr_mdata;
        if (r_state == S_DONE) begin
            r_out.pc     <= r_pc + 16'd1;
            r_out.status <= r_err;
            r_out.out_value <= (op == OP_OUT && r_err == ST_OK) ? reg1 : 32'd0;
            {r_out.flag_over, r_out.flag_under, r_out.flag_carry, r_out.flag_zero}
                <= wr_flags ? calc_flags(res) : r_flags;
        end
    end

    // Beat handling, pc step and commit checks.
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld |-> !i_in.ready) else $error("input taken while result waits");
    a_pc_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE |=> r_pc == $past(r_pc) + 16'd1) else $error("pc step");
    a_no_commit_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err != ST_OK && r_state == S_DONE |-> !wr_reg && !wr_mem && !wr_flags)
        else $error("commit on error");
endmodule
